>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the stick conditioner.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> hw/rtl/asac_pkg.sv
// Package of the stick conditioner: widths, defaults and command structs.
// Depends on nothing; used by all modules of the block.
package asac_pkg;
   localparam int Window = 8;
   localparam int WinBits = 3;
   localparam int Axes = 4;
   localparam int AxBits = 2;
   localparam int AdcW = 12;
   localparam int ScaleW = 24;
   localparam int DzW = 7;
   localparam logic [DzW-1:0] DeadzoneReset = 7'd50;
   localparam logic [6:0] DesiredMax = 7'd127;
   localparam logic [6:0] HalfMax = 7'd63;
   localparam logic [ScaleW-1:0] ScaleSat = 24'hFFFFFF;

   function automatic logic [AdcW-1:0] def_offset(input logic [AxBits-1:0] a);
      logic [AdcW-1:0] r;
      unique case (a)
         2'd0: r = 12'd809;
         2'd1: r = 12'd1110;
         2'd2: r = 12'd995;
         default: r = 12'd693;
      endcase
      return r;
   endfunction

   function automatic logic [ScaleW-1:0] def_normal(input logic [AxBits-1:0] a);
      logic [ScaleW-1:0] r;
      unique case (a)
         2'd0: r = 24'd2549;
         2'd1: r = 24'd2477;
         2'd2: r = 24'd2386;
         default: r = 24'd3742;
      endcase
      return r;
   endfunction

   function automatic logic [ScaleW-1:0] def_calib(input logic [AxBits-1:0] a);
      logic [ScaleW-1:0] r;
      unique case (a)
         2'd0: r = 24'd3991;
         2'd1: r = 24'd3880;
         2'd2: r = 24'd3736;
         default: r = 24'd5865;
      endcase
      return r;
   endfunction

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                store;     // write ring slot, update buttons, mode, spans
      logic                clr_acc;   // clear window sums
      logic                acc;       // add ring slot sel_idx to sums
      logic [WinBits-1:0]  sel_idx;   // ring slot being summed
      logic                div_start; // start division for axis sel_axis
      logic                exit_wr;   // write derived scales for axis sel_axis
      logic                mul;       // multiply axis sel_axis
      logic                fin;       // finish axis sel_axis into result
      logic [AxBits-1:0]   sel_axis;
      logic                load_out;  // capture result register
   } cmd_type;

   typedef struct packed {
      logic fall_exit; // this request leaves calibration
      logic report;    // this request completes a window
      logic div_done;
   } sts_type;
endpackage

>>> hw/rtl/analog_stick_average_calibrate.sv
// Analog stick conditioner: eight-deep moving average with min/max calibration.
// A request that neither reports nor leaves calibration is taken and the next may
// follow at once; a reporting one raises its result after 8 sum steps, 2 steps per
// axis in the shared multiplier and 1 load, and holds the input until then. Leaving
// calibration adds a division per axis in the bit-serial divider.
// Synchronous active-high reset restores default offsets, scales and deadzone 50.
module analog_stick_average_calibrate (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [11:0]       req_adc_ch0,
   input  logic [11:0]       req_adc_ch1,
   input  logic [11:0]       req_adc_ch2,
   input  logic [11:0]       req_adc_ch3,
   input  logic signed [7:0] req_accel_x,
   input  logic signed [7:0] req_accel_z,
   input  logic signed [7:0] req_gyro_x,
   input  logic [3:0]        req_button_pins,
   input  logic              req_mode_pin,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [6:0]        rsp_axis0,
   output logic [6:0]        rsp_axis1,
   output logic [6:0]        rsp_axis2,
   output logic [6:0]        rsp_axis3,
   output logic signed [7:0] rsp_accel_x_avg,
   output logic signed [7:0] rsp_accel_z_avg,
   output logic [6:0]        rsp_gyro_x_avg,
   output logic [3:0]        rsp_buttons,
   output logic              rsp_calibrating,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [6:0]        csr_deadzone
);
   asac_pkg::cmd_type cmd;
   asac_pkg::sts_type sts;
   logic [asac_pkg::DzW-1:0] dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff <= asac_pkg::DeadzoneReset;
      end else if (csr_valid && csr_ready) begin
         dz_ff <= csr_deadzone;
      end
   end

   asac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_ready (csr_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   asac_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .deadzone    (dz_ff),
      .adc_ch0     (req_adc_ch0),
      .adc_ch1     (req_adc_ch1),
      .adc_ch2     (req_adc_ch2),
      .adc_ch3     (req_adc_ch3),
      .accel_x     (req_accel_x),
      .accel_z     (req_accel_z),
      .gyro_x      (req_gyro_x),
      .button_pins (req_button_pins),
      .mode_pin    (req_mode_pin),
      .axis0       (rsp_axis0),
      .axis1       (rsp_axis1),
      .axis2       (rsp_axis2),
      .axis3       (rsp_axis3),
      .accel_x_avg (rsp_accel_x_avg),
      .accel_z_avg (rsp_accel_z_avg),
      .gyro_x_avg  (rsp_gyro_x_avg),
      .buttons     (rsp_buttons),
      .calibrating (rsp_calibrating)
   );
endmodule

>>> hw/rtl/asac_divider.sv
// Restoring divider: two quotients (calib and normal numerators) over one span.
// Depends on asac_pkg; one quotient bit per cycle.
module asac_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [asac_pkg::DzW-1:0]      deadzone,
   input  logic [asac_pkg::AdcW-1:0]     span_lo,
   input  logic [asac_pkg::AdcW-1:0]     span_hi,
   output logic                          done,
   output logic [asac_pkg::ScaleW-1:0]   calib_q,
   output logic [asac_pkg::ScaleW-1:0]   normal_q
);
   // Numerators are at most 254<<16 (24 bits); quotients fit in 24 bits.
   localparam int NumW = 24;
   logic [NumW-1:0] num_c_ff, num_c_in, num_n_ff, num_n_in;
   logic [asac_pkg::AdcW:0] rem_c_ff, rem_c_in, rem_n_ff, rem_n_in;
   logic [asac_pkg::AdcW-1:0] den_ff, den_in;
   logic sat_ff, sat_in;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [asac_pkg::AdcW:0] tc, tn;
   logic [7:0] nc, nn;

   always_comb begin
      nc = {1'b0, deadzone} + {1'b0, asac_pkg::DesiredMax};
      nn = {1'b0, deadzone} + {1'b0, asac_pkg::HalfMax};
      num_c_in = num_c_ff;
      num_n_in = num_n_ff;
      rem_c_in = rem_c_ff;
      rem_n_in = rem_n_ff;
      den_in = den_ff;
      sat_in = sat_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      tc = '0;
      tn = '0;
      if (start) begin
         num_c_in = {nc, 16'd0};
         num_n_in = {nn, 16'd0};
         rem_c_in = '0;
         rem_n_in = '0;
         den_in = span_hi - span_lo;
         sat_in = (span_hi <= span_lo);
         cnt_in = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         tc = {rem_c_ff[asac_pkg::AdcW-1:0], num_c_ff[NumW-1]};
         tn = {rem_n_ff[asac_pkg::AdcW-1:0], num_n_ff[NumW-1]};
         num_c_in = {num_c_ff[NumW-2:0], 1'b0};
         num_n_in = {num_n_ff[NumW-2:0], 1'b0};
         if (tc >= {1'b0, den_ff}) begin
            rem_c_in = tc - {1'b0, den_ff};
            num_c_in[0] = 1'b1;
         end else begin
            rem_c_in = tc;
         end
         if (tn >= {1'b0, den_ff}) begin
            rem_n_in = tn - {1'b0, den_ff};
            num_n_in[0] = 1'b1;
         end else begin
            rem_n_in = tn;
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(NumW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      num_c_ff <= num_c_in;
      num_n_ff <= num_n_in;
      rem_c_ff <= rem_c_in;
      rem_n_ff <= rem_n_in;
      den_ff <= den_in;
      sat_ff <= sat_in;
   end

   // Quotient bits shift into the numerator registers as it drains.
   assign done = busy_ff && !busy_in;
   assign calib_q = sat_ff ? asac_pkg::ScaleSat : num_c_in;
   assign normal_q = sat_ff ? asac_pkg::ScaleSat : num_n_in;
endmodule

>>> hw/rtl/asac_datapath.sv
// Datapath: sample rings, calibration spans, window sums, shared multiplier.
// Depends on asac_pkg and asac_divider.
module asac_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  asac_pkg::cmd_type             cmd,
   output asac_pkg::sts_type             sts,
   input  logic [asac_pkg::DzW-1:0]      deadzone,
   input  logic [11:0]                   adc_ch0,
   input  logic [11:0]                   adc_ch1,
   input  logic [11:0]                   adc_ch2,
   input  logic [11:0]                   adc_ch3,
   input  logic signed [7:0]             accel_x,
   input  logic signed [7:0]             accel_z,
   input  logic signed [7:0]             gyro_x,
   input  logic [3:0]                    button_pins,
   input  logic                          mode_pin,
   output logic [6:0]                    axis0,
   output logic [6:0]                    axis1,
   output logic [6:0]                    axis2,
   output logic [6:0]                    axis3,
   output logic signed [7:0]             accel_x_avg,
   output logic signed [7:0]             accel_z_avg,
   output logic [6:0]                    gyro_x_avg,
   output logic [3:0]                    buttons,
   output logic                          calibrating
);
   localparam int W = asac_pkg::AdcW;
   localparam int A = asac_pkg::Axes;
   localparam int SumW = W + asac_pkg::WinBits;

   logic [A-1:0][W-1:0] aring_ff [asac_pkg::Window];
   logic [2:0][7:0] iring_ff [asac_pkg::Window];
   logic [asac_pkg::WinBits-1:0] ptr_ff;
   logic [asac_pkg::WinBits-1:0] tick_ff;
   logic calib_ff, prev_ff;
   logic [3:0] btn_ff;
   logic [W-1:0] smin_ff [A];
   logic [W-1:0] smax_ff [A];
   logic [W-1:0] off_ff [A];
   logic [asac_pkg::ScaleW-1:0] nsc_ff [A];
   logic [asac_pkg::ScaleW-1:0] csc_ff [A];
   logic [SumW-1:0] asum_ff [A];
   logic signed [10:0] isum_ff [3];
   logic signed [37:0] prod_ff;
   logic [6:0] axr_ff [A];
   logic [6:0] axis_out_ff [A];
   logic signed [7:0] ax_out_ff, az_out_ff;
   logic [6:0] gx_out_ff;
   logic [3:0] btn_out_ff;
   logic cal_out_ff;

   logic [A-1:0][W-1:0] samp;
   logic fall;
   logic div_done;
   logic [asac_pkg::ScaleW-1:0] div_cq, div_nq;
   logic signed [W+1:0] diff;
   logic signed [asac_pkg::ScaleW:0] scale_s;
   logic [37:0] mag;
   logic signed [26:0] t;
   logic signed [27:0] v;
   logic [6:0] clip;
   logic signed [7:0] iavg [3];

   assign samp = {adc_ch3, adc_ch2, adc_ch1, adc_ch0};
   assign fall = !mode_pin && prev_ff;

   asac_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .deadzone (deadzone),
      .span_lo  (smin_ff[cmd.sel_axis]),
      .span_hi  (smax_ff[cmd.sel_axis]),
      .done     (div_done),
      .calib_q  (div_cq),
      .normal_q (div_nq)
   );

   assign sts.fall_exit = fall && calib_ff;
   assign sts.report = (tick_ff == asac_pkg::WinBits'(asac_pkg::Window - 1));
   assign sts.div_done = div_done;

   always_comb begin
      diff = $signed({2'b00, asum_ff[cmd.sel_axis][SumW-1:asac_pkg::WinBits]})
         - $signed({2'b00, off_ff[cmd.sel_axis]});
      scale_s = $signed({1'b0, calib_ff ? csc_ff[cmd.sel_axis] : nsc_ff[cmd.sel_axis]});
      mag = prod_ff[37] ? 38'(-prod_ff) : 38'(prod_ff);
      t = prod_ff[37] ? -27'($signed({1'b0, mag[37:16]}))
                      : 27'($signed({1'b0, mag[37:16]}));
      v = 28'(t) - 28'($signed({1'b0, deadzone})) + (calib_ff ? 28'sd0 : 28'sd63);
      if (v > 28'sd127) begin
         clip = 7'd127;
      end else if (calib_ff ? (v < 28'sd0) : (v < 28'sd63)) begin
         clip = calib_ff ? 7'd0 : 7'd63;
      end else begin
         clip = v[6:0];
      end
      for (int k = 0; k < 3; k++) begin
         // Truncate toward zero: bias negatives before the shift.
         iavg[k] = 8'((isum_ff[k] + (isum_ff[k][10] ? 11'sd7 : 11'sd0)) >>> 3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < asac_pkg::Window; i++) begin
            aring_ff[i] <= '0;
            iring_ff[i] <= '0;
         end
         ptr_ff <= '0;
         tick_ff <= '0;
         calib_ff <= 1'b0;
         prev_ff <= 1'b1;
         btn_ff <= '0;
         for (int a = 0; a < A; a++) begin
            smin_ff[a] <= '0;
            smax_ff[a] <= '0;
            off_ff[a] <= asac_pkg::def_offset(asac_pkg::AxBits'(a));
            nsc_ff[a] <= asac_pkg::def_normal(asac_pkg::AxBits'(a));
            csc_ff[a] <= asac_pkg::def_calib(asac_pkg::AxBits'(a));
         end
      end else begin
         if (cmd.store) begin
            aring_ff[ptr_ff] <= samp;
            iring_ff[ptr_ff] <= {gyro_x, accel_z, accel_x};
            btn_ff <= {~button_pins[0], ~button_pins[2], ~button_pins[3], ~button_pins[1]};
            prev_ff <= mode_pin;
            ptr_ff <= ptr_ff + 1'b1;
            tick_ff <= tick_ff + 1'b1;
            if (fall) begin
               calib_ff <= !calib_ff;
            end else if (calib_ff) begin
               for (int a = 0; a < A; a++) begin
                  if (smin_ff[a] == '0 || samp[a] < smin_ff[a]) smin_ff[a] <= samp[a];
                  if (smax_ff[a] == '0 || samp[a] > smax_ff[a]) smax_ff[a] <= samp[a];
               end
            end
         end
         if (cmd.exit_wr) begin
            off_ff[cmd.sel_axis] <= smin_ff[cmd.sel_axis];
            csc_ff[cmd.sel_axis] <= div_cq;
            nsc_ff[cmd.sel_axis] <= div_nq;
            smin_ff[cmd.sel_axis] <= '0;
            smax_ff[cmd.sel_axis] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_acc) begin
         for (int a = 0; a < A; a++) asum_ff[a] <= '0;
         for (int k = 0; k < 3; k++) isum_ff[k] <= '0;
      end else if (cmd.acc) begin
         for (int a = 0; a < A; a++) begin
            asum_ff[a] <= asum_ff[a] + SumW'(aring_ff[cmd.sel_idx][a]);
         end
         for (int k = 0; k < 3; k++) begin
            isum_ff[k] <= isum_ff[k] + 11'($signed(iring_ff[cmd.sel_idx][k]));
         end
      end
      if (cmd.mul) begin
         prod_ff <= 38'(diff) * 38'(scale_s);
      end
      if (cmd.fin) begin
         axr_ff[cmd.sel_axis] <= clip;
      end
      if (cmd.load_out) begin
         for (int a = 0; a < A; a++) axis_out_ff[a] <= axr_ff[a];
         ax_out_ff <= iavg[0];
         az_out_ff <= iavg[1];
         gx_out_ff <= iavg[2][7] ? 7'd0 : iavg[2][6:0];
         btn_out_ff <= btn_ff;
         cal_out_ff <= calib_ff;
      end
   end

   assign axis0 = axis_out_ff[0];
   assign axis1 = axis_out_ff[1];
   assign axis2 = axis_out_ff[2];
   assign axis3 = axis_out_ff[3];
   assign accel_x_avg = ax_out_ff;
   assign accel_z_avg = az_out_ff;
   assign gyro_x_avg = gx_out_ff;
   assign buttons = btn_out_ff;
   assign calibrating = cal_out_ff;
endmodule

>>> hw/rtl/asac_ctrl.sv
// Controller: sequences store, span exit division, window sums and axis scaling.
// Depends on asac_pkg and assert_macros.svh; drives asac_datapath by command struct.
`include "assert_macros.svh"
module asac_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               csr_ready,
   input  asac_pkg::sts_type  sts,
   output asac_pkg::cmd_type  cmd
);
   typedef enum logic [2:0] {
      IDLE, DIV, DIVW, SUM, MUL, FIN, OUT
   } state_type;

   state_type state_ff, state_in;
   logic [asac_pkg::WinBits-1:0] idx_ff, idx_in;
   logic [asac_pkg::AxBits-1:0] ax_ff, ax_in;
   logic rv_ff, rv_in;
   logic rep_ff, rep_in;
   logic take;

   // A finished window waits in OUT until the output register is free.
   assign req_stall = (state_ff != IDLE);
   assign take = req_valid && !req_stall;
   assign rsp_valid = rv_ff;
   assign csr_ready = (state_ff == IDLE) && !rv_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      ax_in = ax_ff;
      rv_in = rv_ff && rsp_stall;
      rep_in = rep_ff;
      cmd = '0;
      cmd.sel_idx = idx_ff;
      cmd.sel_axis = ax_ff;
      unique case (state_ff)
         IDLE: begin
            if (take) begin
               cmd.store = 1'b1;
               rep_in = sts.report;
               ax_in = '0;
               idx_in = '0;
               cmd.clr_acc = 1'b1;
               if (sts.fall_exit) begin
                  state_in = DIV;
               end else if (sts.report) begin
                  state_in = SUM;
               end
            end
         end
         DIV: begin
            cmd.div_start = 1'b1;
            state_in = DIVW;
         end
         DIVW: begin
            if (sts.div_done) begin
               cmd.exit_wr = 1'b1;
               ax_in = ax_ff + 1'b1;
               if (ax_ff == asac_pkg::AxBits'(asac_pkg::Axes - 1)) begin
                  state_in = rep_ff ? SUM : IDLE;
               end else begin
                  state_in = DIV;
               end
            end
         end
         SUM: begin
            cmd.acc = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == asac_pkg::WinBits'(asac_pkg::Window - 1)) begin
               state_in = MUL;
            end
         end
         MUL: begin
            cmd.mul = 1'b1;
            state_in = FIN;
         end
         FIN: begin
            cmd.fin = 1'b1;
            ax_in = ax_ff + 1'b1;
            state_in = (ax_ff == asac_pkg::AxBits'(asac_pkg::Axes - 1)) ? OUT : MUL;
         end
         OUT: begin
            if (!rv_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rv_in = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         idx_ff <= '0;
         ax_ff <= '0;
         rv_ff <= 1'b0;
         rep_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         ax_ff <= ax_in;
         rv_ff <= rv_in;
         rep_ff <= rep_in;
      end
   end

   `ASSERT_IMPL(a_no_take_busy, clock, reset, state_ff != IDLE, !take, "request taken while busy")
   `ASSERT_NEXT(a_out_valid, clock, reset, state_ff == OUT, rv_ff, "result not raised after load")
   `ASSERT_IMPL(a_single_cmd, clock, reset, 1'b1, $onehot0({cmd.store, cmd.acc, cmd.mul, cmd.fin, cmd.load_out, cmd.div_start}), "overlapping datapath commands")
endmodule
